[src/assert_macros.svh]
// Assertion macros shared by the plotter RTL.
// Depends on nothing; the checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Overlapping implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed in %m");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in %m");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[src/wcp_pkg.sv]
// Types, constants and helper functions for the waveform column plotter.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none
package wcp_pkg;

    localparam logic [2:0] PAGE_LAST  = 3'd7;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] BLANK_BYTE = 8'h00;
    localparam logic [7:0] ONE_BYTE   = 8'h01;

    typedef struct packed {
        logic capture;
        logic emit_run;
        logic emit_blank;
    } wcp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic run_last;
        logic blank_last;
    } wcp_status_t;

    // Page 0 is the top of the display, height 0 the bottom row.
    function automatic logic [2:0] height_to_page(input logic [5:0] h);
        return PAGE_LAST - h[5:3];
    endfunction

    function automatic logic [2:0] height_to_bit(input logic [5:0] h);
        return PAGE_LAST - h[2:0];
    endfunction

endpackage
`default_nettype wire

[src/wcp_datapath.sv]
// Sample registers, page counter, byte generation and output register.
// Depends on wcp_pkg; driven by the commands of wcp_controller.
`default_nettype none
module wcp_datapath
    import wcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [6:0]  column,
    input  wire logic [5:0]  height,
    input  wire wcp_cmd_t    cmd,
    output wcp_status_t      status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    logic [6:0] col_reg;
    logic [2:0] cpage_reg, cbit_reg;
    logic [2:0] ppage_reg, pbit_reg;
    logic [7:0] pmask_reg;
    logic [2:0] pg_reg, lo_reg;
    logic       first_reg, down_reg, same_reg;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] o_page_reg;
    logic [7:0] o_col_reg, o_pix_reg;
    logic       o_last_reg;

    logic [2:0] in_page, in_bit;
    logic [7:0] cmask, run_byte;

    assign in_page = height_to_page(height);
    assign in_bit  = height_to_bit(height);
    assign cmask   = ONE_BYTE << cbit_reg;

    always_comb begin
        if (same_reg) begin
            if (cbit_reg == pbit_reg) begin
                run_byte = cmask;
            end else if (cbit_reg > pbit_reg) begin
                run_byte = (cmask - pmask_reg) | cmask;
            end else begin
                run_byte = pmask_reg - cmask;
            end
        end else if (first_reg) begin
            run_byte = down_reg ? (pmask_reg - ONE_BYTE) : ((cmask << 1) - ONE_BYTE);
        end else if (pg_reg == lo_reg) begin
            // Shift by up to eight, so a previous bit of seven leaves zero.
            run_byte = down_reg ? (FILL_BYTE << cbit_reg)
                                : (FILL_BYTE << ({1'b0, pbit_reg} + 4'd1));
        end else begin
            run_byte = FILL_BYTE;
        end
    end

    assign status.out_free   = !m_valid_reg || m_tready;
    assign status.run_last   = (pg_reg == lo_reg);
    assign status.blank_last = (pg_reg == PAGE_LAST);

    always_comb begin
        if (cmd.emit_run || cmd.emit_blank) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ppage_reg   <= 3'd0;
            pbit_reg    <= 3'd0;
            pmask_reg   <= 8'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.emit_run && status.run_last) begin
                ppage_reg <= cpage_reg;
                pbit_reg  <= cbit_reg;
                pmask_reg <= cmask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            col_reg   <= column;
            cpage_reg <= in_page;
            cbit_reg  <= in_bit;
            first_reg <= 1'b1;
            down_reg  <= (ppage_reg > in_page);
            same_reg  <= (ppage_reg == in_page);
            pg_reg    <= (ppage_reg > in_page) ? ppage_reg : in_page;
            lo_reg    <= (ppage_reg > in_page) ? in_page : ppage_reg;
        end else if (cmd.emit_run) begin
            o_page_reg <= pg_reg;
            o_col_reg  <= {1'b0, col_reg};
            o_pix_reg  <= run_byte;
            o_last_reg <= 1'b0;
            first_reg  <= 1'b0;
            pg_reg     <= status.run_last ? 3'd0 : pg_reg - 3'd1;
        end else if (cmd.emit_blank) begin
            o_page_reg <= pg_reg;
            o_col_reg  <= {1'b0, col_reg} + 8'd1;
            o_pix_reg  <= BLANK_BYTE;
            o_last_reg <= status.blank_last;
            pg_reg     <= pg_reg + 3'd1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, o_pix_reg, o_col_reg, o_page_reg};
    assign m_tlast  = o_last_reg;

endmodule
`default_nettype wire

[src/wcp_controller.sv]
// Sequencer for one sample: capture, run writes, then blanking writes.
// Depends on wcp_pkg; commands the wcp_datapath and reads its status.
`default_nettype none
module wcp_controller
    import wcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire wcp_status_t status,
    output wcp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_BLANK
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.emit_run   = 1'b0;
        cmd.emit_blank = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.out_free) begin
                    cmd.emit_run = 1'b1;
                    if (status.run_last) begin
                        state_next = ST_BLANK;
                    end
                end
            end
            ST_BLANK: begin
                if (status.out_free) begin
                    cmd.emit_blank = 1'b1;
                    if (status.blank_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

[src/waveform_column_plotter.sv]
// Waveform column plotter top level: controller plus datapath.
// Depends on wcp_pkg, wcp_controller, wcp_datapath and assert_macros.svh.
//
// Each accepted sample (column, height) produces the page-display byte writes that draw a
// vertical run in that column from the previous sample's pixel to the new one, followed by
// eight writes that blank the next column from page 0 to page 7; the last of those carries
// tlast. A sample gives between one and eight run writes, so 9 to 16 result transactions in
// all. One result is produced per cycle through the single output register while the output
// is not stalled by m_tready; the sample is first captured, and the next sample can be taken
// only once the last blanking write has been issued. A new sample is accepted while the final
// blanking write still waits in the output register. The previous page, bit
// and mask start at zero after reset, and byte arithmetic wraps modulo 256, so the first
// sample after reset joins from the top row of page 0 with an empty mask.
`default_nettype none
`include "assert_macros.svh"
module waveform_column_plotter
    import wcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // column [6:0], height [12:7], zero fill above
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // page [2:0], target_column [10:3], pixels [18:11]
    output logic             m_tlast
);

    wcp_cmd_t    cmd;
    wcp_status_t status;

    // The controller owns sequencing only; all payload lives in the datapath.
    wcp_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wcp_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .column   (s_tdata[6:0]),
        .height   (s_tdata[12:7]),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // When a sample is accepted, only the final blanking write may still be waiting.
    `ASSERT_IMPL(a_accept_only_after_last, aclk, aresetn,
        s_tvalid && s_tready && m_tvalid, m_tlast)
    // The closing write of a sample always blanks page 7 with an empty byte.
    `ASSERT_IMPL(a_last_is_page7_blank, aclk, aresetn,
        m_tvalid && m_tlast, (m_tdata[2:0] == PAGE_LAST) && (m_tdata[18:11] == BLANK_BYTE))
    // After an accepted sample the block is busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule
`default_nettype wire
